// ===== design/pmrb_pkg.sv =====
// Shared constants, types and the arctangent table of the polar min-range binner.
`default_nettype none
package pmrb_pkg;

  localparam int COORD_W    = 24;  // point coordinate width
  localparam int BIN_NUM_W  = 9;   // bin number field width
  localparam int RANGE_W    = 16;  // range field width
  localparam int CORDIC_W   = 27;  // internal x/y width, covers gain and pre-rotation growth
  localparam int XP_W       = CORDIC_W - 1;  // clamped non-negative magnitude
  localparam int ANG_W      = 34;  // binary angle, 2^32 per turn, with headroom
  localparam int TPOS_W     = ANG_W - 1;  // angle shifted to start at -pi, non-negative
  localparam int GAIN_W     = 30;
  localparam int ATAN_IDX_W = 5;

  localparam int NUM_BINS_DEF     = 360;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic ACT_ADD  = 1'b0;  // add one point
  localparam logic ACT_READ = 1'b1;  // read and clear one bin

  localparam logic [GAIN_W-1:0]         GAIN_Q30    = 30'd652032874;
  localparam logic [RANGE_W-1:0]        EMPTY_RESET = 16'd25856;
  localparam logic signed [ANG_W-1:0]   ANG_QUARTER = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0]   ANG_HALF    = 34'sd2147483648;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CORDIC,
    ST_SCALE,
    ST_BIN,
    ST_LOOK,
    ST_UPDATE,
    ST_RD_REQ,
    ST_RD_DONE
  } state_t;

  typedef struct packed {
    logic done;
    logic bypass;
  } cordic_stat_t;

  // atan(2^-i) in binary angle units (2^32 per turn)
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/pmrb_ifs.sv =====
// Point input, bin result and configuration write channel interfaces.
`default_nettype none
interface pmrb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [pmrb_pkg::COORD_W-1:0]  point_x;
  logic signed [pmrb_pkg::COORD_W-1:0]  point_y;
  logic [pmrb_pkg::BIN_NUM_W-1:0]       read_bin;

  modport source(output valid, action, point_x, point_y, read_bin, input ready);
  modport sink(input valid, action, point_x, point_y, read_bin, output ready);
endinterface

interface pmrb_out_if;
  logic                               valid;
  logic                               ready;
  logic [pmrb_pkg::BIN_NUM_W-1:0]     bin_number;
  logic [pmrb_pkg::RANGE_W-1:0]       bin_range;

  modport source(output valid, bin_number, bin_range, input ready);
  modport sink(input valid, bin_number, bin_range, output ready);
endinterface

interface pmrb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pmrb_pkg::RANGE_W-1:0]   wdata;

  modport source(output valid, wdata, input ready);
  modport sink(input valid, wdata, output ready);
endinterface
`default_nettype wire

// ===== design/pmrb_bin_ram.sv =====
// Single-write, single-read bin store with registered read data.
`default_nettype none
module pmrb_bin_ram #(
  parameter int DEPTH = pmrb_pkg::NUM_BINS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [pmrb_pkg::RANGE_W-1:0]  wdata,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [pmrb_pkg::RANGE_W-1:0]  rdata
);

  logic [pmrb_pkg::RANGE_W-1:0] mem [DEPTH];
  logic [pmrb_pkg::RANGE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== design/pmrb_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle and magnitude out.
`default_nettype none
module pmrb_cordic #(
  parameter int CORDIC_STEPS = pmrb_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic signed [pmrb_pkg::COORD_W-1:0]   x_in,
  input  wire logic signed [pmrb_pkg::COORD_W-1:0]   y_in,
  output pmrb_pkg::cordic_stat_t                     stat,
  output logic [pmrb_pkg::XP_W-1:0]                  x_mag,
  output logic signed [pmrb_pkg::ANG_W-1:0]          angle
);

  localparam int W      = pmrb_pkg::CORDIC_W;
  localparam int AGW    = pmrb_pkg::ANG_W;
  localparam int ITER_W = $clog2(CORDIC_STEPS);

  logic signed [W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [AGW-1:0] z_r, z_nxt;
  logic [ITER_W-1:0]     iter_r, iter_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  bypass_r, bypass_nxt;

  logic signed [W-1:0]   xe, ye, x0, y0, xs, ys;
  logic signed [AGW-1:0] z0;
  logic                  byp;
  logic [31:0]           at;
  logic                  last;

  // pre-rotation into the right half plane; non-negative x axis skips the iterations
  always_comb begin
    xe  = W'(x_in);
    ye  = W'(y_in);
    byp = (y_in == '0) && !x_in[pmrb_pkg::COORD_W-1];
    x0  = xe;
    y0  = ye;
    z0  = '0;
    if (x_in[pmrb_pkg::COORD_W-1]) begin
      if (!y_in[pmrb_pkg::COORD_W-1]) begin
        x0 = ye;
        y0 = -xe;
        z0 = pmrb_pkg::ANG_QUARTER;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -pmrb_pkg::ANG_QUARTER;
      end
    end
  end

  assign xs   = x_r >>> iter_r;
  assign ys   = y_r >>> iter_r;
  assign at   = pmrb_pkg::atan_turn(pmrb_pkg::ATAN_IDX_W'(iter_r));
  assign last = (iter_r == ITER_W'(CORDIC_STEPS - 1));

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    iter_nxt   = iter_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    bypass_nxt = bypass_r;
    if (start) begin
      x_nxt      = x0;
      y_nxt      = y0;
      z_nxt      = z0;
      iter_nxt   = '0;
      busy_nxt   = !byp;
      done_nxt   = byp;
      bypass_nxt = byp;
    end else if (busy_r) begin
      if (!y_r[W-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + AGW'(at);
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - AGW'(at);
      end
      iter_nxt = iter_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      iter_r   <= '0;
      bypass_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      done_r   <= done_nxt;
      iter_r   <= iter_nxt;
      bypass_r <= bypass_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign stat.done   = done_r;
  assign stat.bypass = bypass_r;
  assign x_mag       = x_r[W-1] ? '0 : x_r[W-2:0];
  assign angle       = z_r;

endmodule
`default_nettype wire

// ===== design/polar_min_range_binner_unit.sv =====
// Top level of the polar min-range binner: sequencer, scaling, bin store and ports.
// A point transaction (action 0) runs its (x, y) through a CORDIC stage that does one
// micro-rotation per cycle, then scales the magnitude, maps the angle to one of NUM_BINS bins
// from -pi and keeps the smaller range. A point on the non-negative x axis skips the
// rotations, and a point transaction gives no result. A read transaction (action 1) waits
// until the output register is free, returns the bin's range and refills the bin with
// empty_range; a bin number at or past NUM_BINS returns empty_range and changes nothing.
// One item is worked on at a time; a finished result waits in the output register while
// the next item is taken. After reset the store is filled with the reset empty value in one
// pass over all NUM_BINS bins with in_ch.ready low; cfg_ch writes are taken throughout.
`default_nettype none
module polar_min_range_binner_unit #(
  parameter int NUM_BINS     = pmrb_pkg::NUM_BINS_DEF,
  parameter int CORDIC_STEPS = pmrb_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  pmrb_in_if.sink       in_ch,
  pmrb_out_if.source    out_ch,
  pmrb_cfg_if.sink      cfg_ch
);

  localparam int AW    = $clog2(NUM_BINS);
  localparam int NB_W  = $clog2(NUM_BINS + 1);
  localparam int TW    = pmrb_pkg::TPOS_W;
  localparam int BPW   = TW + NB_W;
  localparam int RPW   = pmrb_pkg::XP_W + pmrb_pkg::GAIN_W;
  localparam int RW    = pmrb_pkg::RANGE_W;
  localparam logic [NB_W-1:0] NUM_BINS_C = NB_W'(NUM_BINS);
  localparam logic [AW-1:0]   LAST_BIN   = AW'(NUM_BINS - 1);

  pmrb_pkg::state_t state_r, state_nxt;

  logic [RW-1:0]                      empty_range_r;
  logic [AW-1:0]                      clr_r;
  logic [pmrb_pkg::BIN_NUM_W-1:0]     rbin_r;
  logic                               rd_ok_r;
  logic [RPW-1:0]                     rng_prod_r;
  logic [BPW-1:0]                     bin_prod_r;
  logic [AW-1:0]                      bin_idx_r;
  logic [RW-1:0]                      rng_r;
  logic                               out_valid_r;
  logic [pmrb_pkg::BIN_NUM_W-1:0]     out_bin_r;
  logic [RW-1:0]                      out_range_r;

  logic                               in_acc, out_acc, out_free, out_load, in_ready;
  logic                               cordic_start;
  pmrb_pkg::cordic_stat_t             cord_st;
  logic [pmrb_pkg::XP_W-1:0]          x_mag;
  logic signed [pmrb_pkg::ANG_W-1:0]  angle;
  logic signed [pmrb_pkg::ANG_W-1:0]  t_ang;
  logic [TW-1:0]                      t_pos;
  logic [BPW-TW:0]                    bin_raw;
  logic [AW-1:0]                      bin_calc;
  logic [pmrb_pkg::XP_W-1:0]          rng_raw;
  logic [RW-1:0]                      rng_calc;
  logic [AW-1:0]                      rd_addr;

  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr, mem_raddr;
  logic [RW-1:0]                      mem_wdata, mem_rdata;

  assign in_acc       = in_ch.valid && in_ready;
  assign out_acc      = out_valid_r && out_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cordic_start = in_acc && (in_ch.action == pmrb_pkg::ACT_ADD);
  assign rd_addr      = AW'(rbin_r);

  pmrb_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .x_in  (in_ch.point_x),
    .y_in  (in_ch.point_y),
    .stat  (cord_st),
    .x_mag (x_mag),
    .angle (angle)
  );

  pmrb_bin_ram #(
    .DEPTH(NUM_BINS),
    .AW   (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // angle measured from -pi; negative spill lands in bin 0, upper spill is clamped
  assign t_ang   = angle + pmrb_pkg::ANG_HALF;
  assign t_pos   = t_ang[pmrb_pkg::ANG_W-1] ? '0 : t_ang[TW-1:0];
  assign bin_raw = bin_prod_r[BPW-1:32];
  assign bin_calc = (bin_raw > (BPW-TW+1)'(NUM_BINS - 1)) ? LAST_BIN : AW'(bin_raw);

  always_comb begin
    rng_raw  = cord_st.bypass ? x_mag : rng_prod_r[RPW-1:30];
    rng_calc = (|rng_raw[pmrb_pkg::XP_W-1:RW]) ? '1 : rng_raw[RW-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pmrb_pkg::ST_CLEAR:   if (clr_r == LAST_BIN) state_nxt = pmrb_pkg::ST_IDLE;
      pmrb_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.action == pmrb_pkg::ACT_READ) ? pmrb_pkg::ST_RD_REQ
                                                           : pmrb_pkg::ST_CORDIC;
        end
      end
      pmrb_pkg::ST_CORDIC:  if (cord_st.done) state_nxt = pmrb_pkg::ST_SCALE;
      pmrb_pkg::ST_SCALE:   state_nxt = pmrb_pkg::ST_BIN;
      pmrb_pkg::ST_BIN:     state_nxt = pmrb_pkg::ST_LOOK;
      pmrb_pkg::ST_LOOK:    state_nxt = pmrb_pkg::ST_UPDATE;
      pmrb_pkg::ST_UPDATE:  state_nxt = pmrb_pkg::ST_IDLE;
      pmrb_pkg::ST_RD_REQ:  state_nxt = pmrb_pkg::ST_RD_DONE;
      pmrb_pkg::ST_RD_DONE: if (out_free) state_nxt = pmrb_pkg::ST_IDLE;
      default:              state_nxt = pmrb_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = bin_idx_r;
    mem_wdata = rng_r;
    mem_raddr = rd_addr;
    unique case (state_r)
      pmrb_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = pmrb_pkg::EMPTY_RESET;
      end
      pmrb_pkg::ST_IDLE:   in_ready = 1'b1;
      pmrb_pkg::ST_LOOK:   mem_raddr = bin_calc;
      pmrb_pkg::ST_UPDATE: mem_we = (rng_r < mem_rdata);
      pmrb_pkg::ST_RD_DONE: begin
        out_load  = out_free;
        mem_we    = out_free && rd_ok_r;
        mem_waddr = rd_addr;
        mem_wdata = empty_range_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pmrb_pkg::ST_CLEAR;
      clr_r         <= '0;
      empty_range_r <= pmrb_pkg::EMPTY_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pmrb_pkg::ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_ch.valid) begin
        empty_range_r <= cfg_ch.wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rbin_r  <= in_ch.read_bin;
      rd_ok_r <= (32'(in_ch.read_bin) < 32'(NUM_BINS));
    end
    if (state_r == pmrb_pkg::ST_SCALE) begin
      rng_prod_r <= x_mag * pmrb_pkg::GAIN_Q30;
    end
    if (state_r == pmrb_pkg::ST_BIN) begin
      bin_prod_r <= t_pos * NUM_BINS_C;
    end
    if (state_r == pmrb_pkg::ST_LOOK) begin
      bin_idx_r <= bin_calc;
      rng_r     <= rng_calc;
    end
    if (out_load) begin
      out_bin_r   <= rbin_r;
      out_range_r <= rd_ok_r ? mem_rdata : empty_range_r;
    end
  end

  assign in_ch.ready       = in_ready;
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.bin_number = out_bin_r;
  assign out_ch.bin_range  = out_range_r;

  a_waddr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < 32'(NUM_BINS)))
    else $error("bin store write past last bin");

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    cord_st.done |-> (state_r == pmrb_pkg::ST_CORDIC))
    else $error("CORDIC finished while sequencer was not waiting for it");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == pmrb_pkg::ST_RD_DONE))
    else $error("result raised outside a read transaction");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("new transaction taken while one is in work");

endmodule
`default_nettype wire
